>>> rtl/multi_pin_debouncer_events_core_macros.svh
// Assertion macros used by the port-level checker file of the debouncer bank.
`ifndef MULTI_PIN_DEBOUNCER_EVENTS_CORE_MACROS_SVH
`define MULTI_PIN_DEBOUNCER_EVENTS_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DBE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("debouncer bank check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DBE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("debouncer bank check failed");

`endif

>>> rtl/dbe_pkg.sv
// Shared types and constants of the debouncer bank.
`default_nettype none

package dbe_pkg;

    localparam int FIELD_W   = 8;
    localparam int TIME_W    = 32;
    localparam int DELAY_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    localparam logic [DELAY_W-1:0] DELAY_RESET  = 16'd40;
    localparam logic [FIELD_W-1:0] ENABLE_RESET = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LEVELS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_ENABLE_MASK = 2'd2;

    // Per-cycle control that fans out to every lane and to the merge stage.
    typedef struct packed {
        logic accept;
        logic load_rest;
    } t_lane_ctl;

endpackage

`default_nettype wire

>>> rtl/dbe_lane.sv
// One debouncer lane: timer, last raw sample and debounced level of one pin.
`default_nettype none

module dbe_lane (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  dbe_pkg::t_lane_ctl            i_ctl,
    input  wire                           i_raw,
    input  wire  [dbe_pkg::TIME_W-1:0]    i_now,
    input  wire  [dbe_pkg::DELAY_W-1:0]   i_delay,
    input  wire                           i_rest,
    output logic                          o_stable
);

    logic [dbe_pkg::TIME_W-1:0] r_stamp, n_stamp;
    logic                       r_prev, n_prev;
    logic                       r_stable, n_stable;
    logic [dbe_pkg::TIME_W-1:0] w_elapsed;
    logic                       w_changed;
    logic                       w_expired;
    logic                       w_new_stable;

    always_comb begin
        w_changed    = i_raw != r_prev;
        w_elapsed    = i_now - r_stamp;
        w_expired    = !w_changed &&
                       (w_elapsed > {{(dbe_pkg::TIME_W-dbe_pkg::DELAY_W){1'b0}}, i_delay});
        w_new_stable = w_expired ? i_raw : r_stable;
    end

    always_comb begin
        n_stamp  = r_stamp;
        n_prev   = r_prev;
        n_stable = r_stable;
        if (i_ctl.load_rest) begin
            // The timer keeps running across a rest-level write.
            n_prev   = i_rest;
            n_stable = i_rest;
        end else if (i_ctl.accept) begin
            if (w_changed || w_expired) begin
                n_stamp = i_now;
            end
            n_prev   = i_raw;
            n_stable = w_new_stable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp  <= '0;
            r_prev   <= 1'b0;
            r_stable <= 1'b0;
        end else begin
            r_stamp  <= n_stamp;
            r_prev   <= n_prev;
            r_stable <= n_stable;
        end
    end

    // The merge stage sees the level this word leaves behind.
    assign o_stable = w_new_stable;

endmodule

`default_nettype wire

>>> rtl/dbe_merge.sv
// Merge stage: event flags against the reported levels and the result register.
`default_nettype none

module dbe_merge #(
    parameter int LANES = 8
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  dbe_pkg::t_lane_ctl             i_ctl,
    input  wire  [LANES-1:0]               i_stable,
    input  wire  [LANES-1:0]               i_rest,
    input  wire  [LANES-1:0]               i_enable,
    input  wire  [LANES-1:0]               i_load_value,
    input  wire                            i_out_ready,
    output logic                           o_out_valid,
    output logic [dbe_pkg::FIELD_W-1:0]    o_act,
    output logic [dbe_pkg::FIELD_W-1:0]    o_deact,
    output logic [dbe_pkg::FIELD_W-1:0]    o_levels
);

    logic [LANES-1:0]            r_reported, n_reported;
    logic [LANES-1:0]            w_act, w_deact;
    logic                        r_valid, n_valid;
    logic [dbe_pkg::FIELD_W-1:0] r_act, r_deact, r_levels;
    logic [dbe_pkg::FIELD_W-1:0] n_act, n_deact, n_levels;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_act[i]   = i_enable[i] && (i_stable[i] != r_reported[i]) &&
                         (i_stable[i] != i_rest[i]);
            w_deact[i] = i_enable[i] && (i_stable[i] != r_reported[i]) &&
                         (i_stable[i] == i_rest[i]);
        end
    end

    always_comb begin
        n_reported = r_reported;
        if (i_ctl.load_rest) begin
            n_reported = i_load_value;
        end else if (i_ctl.accept) begin
            // A disabled pin holds its reported level so the change stays pending.
            n_reported = (i_stable & i_enable) | (r_reported & ~i_enable);
        end
    end

    always_comb begin
        n_valid  = r_valid && !i_out_ready;
        n_act    = r_act;
        n_deact  = r_deact;
        n_levels = r_levels;
        if (i_ctl.accept) begin
            n_valid  = 1'b1;
            n_act    = '0;
            n_deact  = '0;
            n_levels = '0;
            n_act[LANES-1:0]    = w_act;
            n_deact[LANES-1:0]  = w_deact;
            n_levels[LANES-1:0] = i_stable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reported <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_reported <= n_reported;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_deact  <= n_deact;
        r_levels <= n_levels;
    end

    assign o_out_valid = r_valid;
    assign o_act       = r_act;
    assign o_deact     = r_deact;
    assign o_levels    = r_levels;

endmodule

`default_nettype wire

>>> rtl/multi_pin_debouncer_events_core.sv
// Top level of the debouncer bank with activation and deactivation events.
//
//  channel | dir | handshake                 | payload
//  s       | in  | i_s_tvalid / o_s_tready   | raw levels, millisecond time
//  m       | out | o_m_tvalid / i_m_tready   | activated, deactivated, debounced
//  cfg     | in  | i_cfg_we                  | register index, write data
//
// One word per clock while the output is not stalled: every pin lane does its subtract
// and compare in the accept cycle and the result lands in the output register in the cycle after.
// A new word is taken whenever the output register is empty or being drained.
// Reset clears all timers and levels, loads a 40 ms delay and enables all pins.
// A stalled output holds its word and pauses the input side only.
`default_nettype none

module multi_pin_debouncer_events_core #(
    parameter int NUM_PINS = 8
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    // [7:0] raw_levels, [39:8] time_ms
    input  wire  [dbe_pkg::IN_DATA_W-1:0]      i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    // [7:0] activated_mask, [15:8] deactivated_mask, [23:16] debounced_levels
    output logic [dbe_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input  wire                                i_cfg_we,
    input  wire  [dbe_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  wire  [dbe_pkg::CFG_DAT_W-1:0]      i_cfg_wdata
);

    // Only pins that fit the 8-bit fields get a lane.
    localparam int LANES = (NUM_PINS < dbe_pkg::FIELD_W) ? NUM_PINS : dbe_pkg::FIELD_W;

    logic [dbe_pkg::DELAY_W-1:0] r_delay;
    logic [LANES-1:0]            r_rest;
    logic [LANES-1:0]            r_enable;
    dbe_pkg::t_lane_ctl          w_ctl;
    logic [LANES-1:0]            w_stable;
    logic [dbe_pkg::FIELD_W-1:0] w_raw;
    logic [dbe_pkg::TIME_W-1:0]  w_now;
    logic                        w_out_valid;
    logic [dbe_pkg::FIELD_W-1:0] w_act, w_deact, w_levels;

    assign w_raw = i_s_tdata[dbe_pkg::FIELD_W-1:0];
    assign w_now = i_s_tdata[dbe_pkg::FIELD_W +: dbe_pkg::TIME_W];

    assign o_s_tready    = !w_out_valid || i_m_tready;
    assign w_ctl.accept  = i_s_tvalid && o_s_tready;
    assign w_ctl.load_rest = i_cfg_we && (i_cfg_addr == dbe_pkg::CFG_REST_LEVELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= dbe_pkg::DELAY_RESET;
            r_rest   <= '0;
            r_enable <= dbe_pkg::ENABLE_RESET[LANES-1:0];
        end else if (i_cfg_we) begin
            if (i_cfg_addr == dbe_pkg::CFG_DEBOUNCE_DELAY) begin
                r_delay <= i_cfg_wdata;
            end
            if (i_cfg_addr == dbe_pkg::CFG_REST_LEVELS) begin
                r_rest <= i_cfg_wdata[LANES-1:0];
            end
            if (i_cfg_addr == dbe_pkg::CFG_PIN_ENABLE_MASK) begin
                r_enable <= i_cfg_wdata[LANES-1:0];
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        dbe_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_raw    (w_raw[g]),
            .i_now    (w_now),
            .i_delay  (r_delay),
            .i_rest   (i_cfg_wdata[g]),
            .o_stable (w_stable[g])
        );
    end

    dbe_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_stable     (w_stable),
        .i_rest       (r_rest),
        .i_enable     (r_enable),
        .i_load_value (i_cfg_wdata[LANES-1:0]),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (w_out_valid),
        .o_act        (w_act),
        .o_deact      (w_deact),
        .o_levels     (w_levels)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = {w_levels, w_deact, w_act};

endmodule

`default_nettype wire

>>> rtl/dbe_checker.sv
// Port-level checks of the debouncer bank and the bind that attaches them.
`default_nettype none
`include "multi_pin_debouncer_events_core_macros.svh"

module dbe_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_tvalid,
    input  wire                             o_s_tready,
    input  wire                             o_m_tvalid,
    input  wire                             i_m_tready,
    input  wire [dbe_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    // A word held back by the sink keeps its contents.
    `DBE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // A pin cannot both leave and return to rest in the same word.
    `DBE_ASSERT_NOW(a_events_disjoint, i_clk, i_rst_n, o_m_tvalid, (o_m_tdata[7:0] & o_m_tdata[15:8]) == 8'd0)

    // An empty output register never blocks the input side.
    `DBE_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)

    // Every accepted word shows up as a result on the next cycle.
    `DBE_ASSERT_NEXT(a_accept_to_result, i_clk, i_rst_n, i_s_tvalid && o_s_tready, o_m_tvalid)

endmodule

bind multi_pin_debouncer_events_core dbe_checker u_dbe_checker (.*);

`default_nettype wire

>>> verif/dbe_event_checker.sv
// Checker for the debouncer bank: predicts each result word and compares it with the output.
`timescale 1ns / 1ps

module dbe_event_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_tvalid,
    input  wire                            i_s_tready,
    // [7:0] raw_levels, [39:8] time_ms
    input  wire  [dbe_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  wire                            i_m_tvalid,
    input  wire                            i_m_tready,
    // [7:0] activated_mask, [15:8] deactivated_mask, [23:16] debounced_levels
    input  wire  [dbe_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  wire                            i_cfg_we,
    input  wire  [dbe_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire  [dbe_pkg::CFG_DAT_W-1:0]  i_cfg_wdata,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        logic [dbe_pkg::FIELD_W-1:0] activated;
        logic [dbe_pkg::FIELD_W-1:0] deactivated;
        logic [dbe_pkg::FIELD_W-1:0] levels;
    } t_event_word;

    // Shadow copy of the block's registers and per-pin state.
    logic [dbe_pkg::DELAY_W-1:0] delay_ms;
    logic [dbe_pkg::FIELD_W-1:0] rest_lvl;
    logic [dbe_pkg::FIELD_W-1:0] enable_lvl;
    logic [dbe_pkg::TIME_W-1:0]  pin_stamp [dbe_pkg::FIELD_W];
    logic [dbe_pkg::FIELD_W-1:0] last_raw;
    logic [dbe_pkg::FIELD_W-1:0] stable_lvl;
    logic [dbe_pkg::FIELD_W-1:0] reported_lvl;

    t_event_word expected_words [$];
    t_event_word want_word;
    t_event_word got_word;
    int          fail_total = 0;

    task automatic clear_state();
        delay_ms     = dbe_pkg::DELAY_RESET;
        rest_lvl     = '0;
        enable_lvl   = dbe_pkg::ENABLE_RESET;
        last_raw     = '0;
        stable_lvl   = '0;
        reported_lvl = '0;
        for (int i = 0; i < dbe_pkg::FIELD_W; i++) begin
            pin_stamp[i] = '0;
        end
    endtask

    task automatic debounce_word(input logic [dbe_pkg::FIELD_W-1:0] raw,
                                 input logic [dbe_pkg::TIME_W-1:0] now,
                                 output t_event_word word);
        logic [dbe_pkg::TIME_W-1:0] elapsed;
        word = '0;
        for (int i = 0; i < dbe_pkg::FIELD_W; i++) begin
            elapsed = now - pin_stamp[i];
            if (raw[i] != last_raw[i]) begin
                pin_stamp[i] = now;
            end else if (elapsed >
                         {{(dbe_pkg::TIME_W-dbe_pkg::DELAY_W){1'b0}}, delay_ms}) begin
                pin_stamp[i]  = now;
                stable_lvl[i] = raw[i];
            end
            last_raw[i] = raw[i];
        end
        // A disabled pin keeps its old reported level, so its change shows up later.
        for (int i = 0; i < dbe_pkg::FIELD_W; i++) begin
            if (enable_lvl[i]) begin
                if (stable_lvl[i] != reported_lvl[i]) begin
                    if (stable_lvl[i] == rest_lvl[i]) begin
                        word.deactivated[i] = 1'b1;
                    end else begin
                        word.activated[i] = 1'b1;
                    end
                end
                reported_lvl[i] = stable_lvl[i];
            end
        end
        word.levels = stable_lvl;
    endtask

    task automatic check_field(input string what, input logic [dbe_pkg::FIELD_W-1:0] want,
                               input logic [dbe_pkg::FIELD_W-1:0] got);
        if (want !== got) begin
            fail_total++;
            $display("%0t: %s expected %02h, got %02h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            expected_words.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got_word.activated   = i_m_tdata[7:0];
                got_word.deactivated = i_m_tdata[15:8];
                got_word.levels      = i_m_tdata[23:16];
                if (expected_words.size() == 0) begin
                    fail_total++;
                    $display("%0t: result word %06h expected none, got one", $time,
                             i_m_tdata);
                end else begin
                    want_word = expected_words.pop_front();
                    check_field("activated mask", want_word.activated, got_word.activated);
                    check_field("deactivated mask", want_word.deactivated,
                                got_word.deactivated);
                    check_field("debounced levels", want_word.levels, got_word.levels);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                debounce_word(i_s_tdata[7:0], i_s_tdata[39:8], want_word);
                expected_words.push_back(want_word);
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    dbe_pkg::CFG_DEBOUNCE_DELAY: begin
                        delay_ms = i_cfg_wdata[dbe_pkg::DELAY_W-1:0];
                    end
                    dbe_pkg::CFG_REST_LEVELS: begin
                        rest_lvl     = i_cfg_wdata[dbe_pkg::FIELD_W-1:0];
                        last_raw     = rest_lvl;
                        stable_lvl   = rest_lvl;
                        reported_lvl = rest_lvl;
                    end
                    dbe_pkg::CFG_PIN_ENABLE_MASK: begin
                        enable_lvl = i_cfg_wdata[dbe_pkg::FIELD_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending    <= expected_words.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> verif/testbench.sv
// Top of the debouncer bank testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam logic [dbe_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 190;
    localparam int HOLD_CYCLES   = 150;
    localparam int HOLD_AT_FIRST = 700;
    localparam int HOLD_AT_LAST  = 1300;
    localparam int STUCK_LIMIT   = 2000;

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [dbe_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dbe_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           cfg_we = 1'b0;
    logic [dbe_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [dbe_pkg::CFG_DAT_W-1:0]  cfg_wdata = '0;

    int fail_count;
    int pending;

    int send_idle_pct = 34;
    int recv_idle_pct = 68;
    int hold_left     = 0;
    int results_taken = 0;
    int words_sent    = 0;
    int cfg_writes    = 0;
    int stuck_cycles  = 0;

    logic [dbe_pkg::DELAY_W-1:0] cur_delay = dbe_pkg::DELAY_RESET;
    logic [dbe_pkg::FIELD_W-1:0] raw_lvl   = '0;
    logic [dbe_pkg::TIME_W-1:0]  now_ms    = '0;

    multi_pin_debouncer_events_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    dbe_event_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Output side: random stalls, plus two long holds that back the block up.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_taken <= results_taken + 1;
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (m_tvalid && m_tready &&
                         (results_taken == HOLD_AT_FIRST || results_taken == HOLD_AT_LAST)) begin
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic put_word(input logic [dbe_pkg::FIELD_W-1:0] raw,
                            input logic [dbe_pkg::TIME_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t, raw};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
    endtask

    // Registers change only with nothing in flight; the wait after the pending count reaches
    // zero covers the result register and the lag of that count.
    task automatic write_reg(input logic [dbe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dbe_pkg::CFG_DAT_W-1:0] data);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
        if (idx == dbe_pkg::CFG_DEBOUNCE_DELAY) begin
            cur_delay = data;
        end
    endtask

    // Time steps cluster around the debounce threshold so both sides of it are hit.
    function automatic logic [dbe_pkg::TIME_W-1:0] pick_gap(
        input logic [dbe_pkg::DELAY_W-1:0] d);
        int unsigned dd;
        dd = {{(32-dbe_pkg::DELAY_W){1'b0}}, d};
        case ($urandom_range(3))
            0: pick_gap = $urandom_range(2);
            1: pick_gap = $urandom_range(dd + 2);
            2: pick_gap = (dd == 0) ? $urandom_range(1) : dd - 1 + $urandom_range(2);
            default: pick_gap = $urandom_range(2 * dd + 5);
        endcase
    endfunction

    task automatic run_phase(input int count);
        logic [dbe_pkg::FIELD_W-1:0] flips;
        logic [dbe_pkg::CFG_DAT_W-1:0] mask_word;
        for (int k = 0; k < count; k++) begin
            if (k == count / 2) begin
                mask_word = 16'($urandom_range(65535));
                write_reg(dbe_pkg::CFG_PIN_ENABLE_MASK, mask_word);
            end
            if ($urandom_range(99) < 8) begin
                // Glitch: arbitrary levels at an arbitrary, often backward, time.
                put_word(8'($urandom_range(255)), $urandom);
            end else begin
                now_ms = now_ms + pick_gap(cur_delay);
                if ($urandom_range(3) == 0) begin
                    flips   = 8'($urandom_range(255) & $urandom_range(255));
                    raw_lvl = raw_lvl ^ flips;
                end
                put_word(raw_lvl, now_ms);
            end
        end
    endtask

    initial begin
        logic [dbe_pkg::DELAY_W-1:0] ph_delay;
        logic [dbe_pkg::FIELD_W-1:0] ph_rest;
        logic [dbe_pkg::FIELD_W-1:0] ph_enable;
        logic [dbe_pkg::FIELD_W-1:0] junk;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: settle both ways, the exact threshold, wrap and backward time.
        put_word(8'h00, 32'd0);
        put_word(8'hFF, 32'd1);
        put_word(8'hFF, 32'd41);
        put_word(8'hFF, 32'd42);
        put_word(8'hFF, 32'd43);
        put_word(8'h00, 32'd100);
        put_word(8'h00, 32'd141);
        put_word(8'h5A, 32'hFFFF_FFF0);
        put_word(8'h5A, 32'h0000_0020);
        put_word(8'h5A, 32'h0000_0010);
        put_word(8'hA5, 32'hFFFF_FFFF);
        put_word(8'hA5, 32'h7FFF_FFFF);
        // Disabled pins hold their change until they are enabled again.
        write_reg(dbe_pkg::CFG_PIN_ENABLE_MASK, 16'hFF0F);
        put_word(8'hF0, 32'h8000_0000);
        put_word(8'hF0, 32'h8000_0100);
        write_reg(dbe_pkg::CFG_PIN_ENABLE_MASK, 16'h00FF);
        put_word(8'hF0, 32'h8000_0101);
        write_reg(dbe_pkg::CFG_DEBOUNCE_DELAY, 16'h0000);
        put_word(8'h0F, 32'h8000_0101);
        put_word(8'h0F, 32'h8000_0101);
        put_word(8'h0F, 32'h8000_0102);
        write_reg(dbe_pkg::CFG_REST_LEVELS, 16'hAB33);
        put_word(8'h33, 32'h8000_0200);
        put_word(8'hCC, 32'h8000_0205);
        put_word(8'hCC, 32'h8000_0206);
        write_reg(CFG_SPARE, 16'hFFFF);
        put_word(8'hCC, 32'h8000_0207);
        write_reg(dbe_pkg::CFG_DEBOUNCE_DELAY, 16'hFFFF);
        put_word(8'h00, 32'h8000_0208);
        put_word(8'h00, 32'h8001_0207);
        put_word(8'h00, 32'h8001_0208);

        now_ms = 32'h0001_0000;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin ph_delay = 16'd40;    ph_rest = 8'h00; ph_enable = 8'hFF; end
                1: begin ph_delay = 16'd0;     ph_rest = 8'hFF; ph_enable = 8'hFF; end
                2: begin ph_delay = 16'hFFFF;  ph_rest = 8'hA5; ph_enable = 8'h0F; end
                3: begin ph_delay = 16'd3;     ph_rest = 8'h00; ph_enable = 8'h00; end
                4: begin ph_delay = 16'd12;    ph_rest = 8'h3C; ph_enable = 8'hF0; end
                5: begin ph_delay = 16'd1;     ph_rest = 8'h0F; ph_enable = 8'hFF; end
                6: begin ph_delay = 16'd1000;  ph_rest = 8'h81; ph_enable = 8'h55; end
                default: begin ph_delay = 16'd5; ph_rest = 8'hFF; ph_enable = 8'hAA; end
            endcase
            if (p == 3) begin
                send_idle_pct = 68;
                recv_idle_pct <= 34;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            if (p == 5) begin
                // Start this phase just below the 32-bit wrap of the millisecond counter.
                now_ms = 32'hFFFF_F000;
            end
            write_reg(dbe_pkg::CFG_DEBOUNCE_DELAY, ph_delay);
            junk = 8'($urandom_range(255));
            write_reg(dbe_pkg::CFG_REST_LEVELS, {junk, ph_rest});
            junk = 8'($urandom_range(255));
            write_reg(dbe_pkg::CFG_PIN_ENABLE_MASK, {junk, ph_enable});
            raw_lvl = ph_rest;
            run_phase(PHASE_WORDS);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d sample words, checked %0d result words, %0d register writes.",
                 words_sent, results_taken, cfg_writes);
        $display("Covered eight delay/rest/enable settings, wrapped and backward time, "
                 , "and long output holds.");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/dbe_pkg.sv
rtl/dbe_lane.sv
rtl/dbe_merge.sv
rtl/multi_pin_debouncer_events_core.sv
rtl/dbe_checker.sv
verif/dbe_event_checker.sv
verif/testbench.sv
